### rtl/ba_pkg.sv
`timescale 1ns / 1ps

package ba_pkg;

  localparam int unsigned MaxLevelsDefault = 11;

  localparam logic [4:0] LargestReset  = 5'd10;
  localparam logic [4:0] SmallestReset = 5'd0;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindFree  = 2'd1;
  localparam logic [1:0] KindSplit = 2'd2;
  localparam logic [1:0] KindData  = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNoSpace   = 3'd1;
  localparam logic [2:0] StUnaligned = 3'd2;
  localparam logic [2:0] StRange     = 3'd3;
  localparam logic [2:0] StNotAlloc  = 3'd4;
  localparam logic [2:0] StBadCfg    = 3'd5;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic CfgLargest  = 1'b0;
  localparam logic CfgSmallest = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] count;
    logic [31:0] start_index;
  } req_t;

  typedef struct packed {
    logic [31:0] result_index;
    logic [2:0]  status;
  } rsp_t;

endpackage

### rtl/ba_stream_if.sv
`timescale 1ns / 1ps

interface ba_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/ba_node_mem.sv
`timescale 1ns / 1ps

// Node store: kind, previous link and next link for every node, one port,
// with registered read data. After reset and on clear_i every node is
// rewritten one per cycle, with busy_o high until the last node is written.
module ba_node_mem #(
  parameter int unsigned MaxLevels = ba_pkg::MaxLevelsDefault,
  localparam int unsigned Depth = (1 << MaxLevels) - 1,
  localparam int unsigned AddrW = MaxLevels,
  localparam int unsigned LinkW = MaxLevels + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  output logic             busy_o,
  input  logic [AddrW-1:0] addr_i,
  input  logic             we_kind_i,
  input  logic [1:0]       wkind_i,
  input  logic             we_prev_i,
  input  logic [LinkW-1:0] wprev_i,
  input  logic             we_next_i,
  input  logic [LinkW-1:0] wnext_i,
  output logic [1:0]       rkind_o,
  output logic [LinkW-1:0] rprev_o,
  output logic [LinkW-1:0] rnext_o
);
  logic [1:0]       kind_q [Depth];
  logic [LinkW-1:0] prev_q [Depth];
  logic [LinkW-1:0] next_q [Depth];
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;
  logic [AddrW-1:0] addr;
  logic             wk, wp, wn;
  logic [1:0]       kind_w;
  logic [LinkW-1:0] prev_w, next_w;
  logic [1:0]       rkind_q;
  logic [LinkW-1:0] rprev_q, rnext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_i) begin
      clr_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) clr_q <= 1'b0;
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  always_comb begin
    addr = addr_i;
    wk = we_kind_i;
    wp = we_prev_i;
    wn = we_next_i;
    kind_w = wkind_i;
    prev_w = wprev_i;
    next_w = wnext_i;
    if (clr_q) begin
      addr = clr_addr_q;
      wk = 1'b1;
      wp = 1'b1;
      wn = 1'b1;
      kind_w = (clr_addr_q == '0) ? ba_pkg::KindFree : ba_pkg::KindNone;
      prev_w = '1;
      next_w = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wk) kind_q[addr] <= kind_w;
    if (wp) prev_q[addr] <= prev_w;
    if (wn) next_q[addr] <= next_w;
    rkind_q <= kind_q[addr];
    rprev_q <= prev_q[addr];
    rnext_q <= next_q[addr];
  end

  assign busy_o  = clr_q;
  assign rkind_o = rkind_q;
  assign rprev_o = rprev_q;
  assign rnext_o = rnext_q;
endmodule

### rtl/ba_core.sv
`timescale 1ns / 1ps

module ba_core #(
  parameter int unsigned MaxLevels = ba_pkg::MaxLevelsDefault,
  localparam int unsigned AddrW = MaxLevels,
  localparam int unsigned LinkW = MaxLevels + 1,
  localparam int unsigned LvlW = $clog2(MaxLevels + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_idx_ok_i,
  input  logic [4:0]  cfg_val_i,
  ba_stream_if.sink   req,
  ba_stream_if.source rsp
);
  typedef enum logic [13:0] {
    SIdle    = 14'b00000000000001,
    SSearch  = 14'b00000000000010,
    SPopRd   = 14'b00000000000100,
    SPop     = 14'b00000000001000,
    SPopFix  = 14'b00000000010000,
    SSplit   = 14'b00000000100000,
    SPush    = 14'b00000001000000,
    SWalkRd  = 14'b00000010000000,
    SWalk    = 14'b00000100000000,
    SDrop    = 14'b00001000000000,
    SMergeRd = 14'b00010000000000,
    SMerge   = 14'b00100000000000,
    SUnlink  = 14'b01000000000000,
    SDone    = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [4:0]       lg_q, sm_q;
  logic             ok_q;
  logic [LvlW-1:0]  deep_q;
  logic [LinkW-1:0] head_q [MaxLevels];
  logic [LvlW-1:0]  lvl_q, lvl_d, want_q, want_d;
  logic [AddrW-1:0] n_q, n_d;
  logic [LinkW-1:0] t_q, t_d;
  logic [LinkW-1:0] bp_q, bp_d;
  logic             fix_q, fix_d;
  logic             mrg_q, mrg_d;
  logic [31:0]      res_q, res_d;
  logic [2:0]       st_q, st_d;
  logic             ovalid_q;
  ba_pkg::rsp_t     out_q;
  logic             clear;
  logic             busy;

  logic             m_wk, m_wp, m_wn;
  logic [AddrW-1:0] m_addr;
  logic [1:0]       m_kind, r_kind;
  logic [LinkW-1:0] m_prev, m_next, r_prev, r_next;
  logic             h_we;
  logic [LvlW-1:0]  h_lvl;
  logic [LinkW-1:0] h_val;
  logic [AddrW-1:0] push_n;

  ba_pkg::req_t     rq;
  logic [32:0]      need;
  logic [32:0]      q33;
  logic [31:0]      qv;
  logic [LvlW-1:0]  clog, low;

  function automatic logic [AddrW-1:0] slot(input logic [LvlW-1:0] l,
                                            input logic [AddrW-1:0] i);
    logic [AddrW:0] s;
    s = ((AddrW+1)'(1) << l) - (AddrW+1)'(1) + {1'b0, i};
    return s[AddrW-1:0];
  endfunction

  assign rq = req.data;
  assign clear = cfg_we_i && cfg_idx_ok_i;

  ba_node_mem #(.MaxLevels(MaxLevels)) u_mem (
    .clk_i, .rst_ni, .clear_i(clear), .busy_o(busy), .addr_i(m_addr),
    .we_kind_i(m_wk), .wkind_i(m_kind), .we_prev_i(m_wp), .wprev_i(m_prev),
    .we_next_i(m_wn), .wnext_i(m_next),
    .rkind_o(r_kind), .rprev_o(r_prev), .rnext_o(r_next)
  );

  always_comb begin
    need = ({1'b0, rq.count} + ((33'd1 << sm_q) - 33'd1)) >> sm_q;
    clog = '0;
    for (int k = 1; k <= MaxLevels; k++) begin
      if (need > (33'd1 << (k - 1))) clog = LvlW'(k);
    end
    qv  = rq.start_index >> sm_q;
    q33 = {1'b0, qv} << sm_q;
    low = deep_q;
    for (int k = MaxLevels - 1; k >= 0; k--) begin
      if (qv[k]) low = LvlW'(k);
    end
  end

  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q; want_d = want_q; n_d = n_q; t_d = t_q; bp_d = bp_q;
    fix_d = fix_q; mrg_d = mrg_q; res_d = res_q; st_d = st_q;
    m_addr = slot(lvl_q, n_q);
    m_wk = 1'b0; m_wp = 1'b0; m_wn = 1'b0;
    m_kind = ba_pkg::KindNone; m_prev = '1; m_next = '1;
    h_we = 1'b0; h_lvl = lvl_q; h_val = '1;
    push_n = mrg_q ? n_q : (n_q ^ AddrW'(1));
    case (state_q)
      SIdle: begin
        if (req.valid && !busy) begin
          res_d = '0; st_d = ba_pkg::StOk; mrg_d = 1'b0; state_d = SDone;
          if (!ok_q) begin
            st_d = ba_pkg::StBadCfg;
          end else if (rq.op == ba_pkg::OpAlloc) begin
            if (rq.count == '0) begin
              res_d = 32'd1 << lg_q;
            end else if (need > (33'd1 << deep_q)) begin
              st_d = ba_pkg::StNoSpace;
            end else begin
              want_d = deep_q - clog; lvl_d = deep_q - clog;
              state_d = SSearch;
            end
          end else begin
            if (q33 != {1'b0, rq.start_index}) begin
              st_d = ba_pkg::StUnaligned;
            end else if ({1'b0, qv} >= (33'd1 << deep_q)) begin
              if ({1'b0, qv} != (33'd1 << deep_q)) st_d = ba_pkg::StRange;
            end else begin
              lvl_d = (qv == '0) ? '0 : deep_q - low;
              n_d = AddrW'(qv >> ((qv == '0) ? deep_q : low));
              state_d = SWalkRd;
            end
          end
        end
      end
      SSearch: begin
        if (!head_q[lvl_q][LinkW-1]) begin
          n_d = head_q[lvl_q][AddrW-1:0]; state_d = SPopRd;
        end else if (lvl_q == '0) begin
          st_d = ba_pkg::StNoSpace; state_d = SDone;
        end else begin
          lvl_d = lvl_q - 1'b1;
        end
      end
      SPopRd: begin
        state_d = SPop;
      end
      SPop: begin
        h_we = 1'b1; h_val = r_next; t_d = r_next;
        state_d = r_next[LinkW-1] ? SSplit : SPopFix;
      end
      SPopFix: begin
        m_addr = slot(lvl_q, t_q[AddrW-1:0]); m_wp = 1'b1;
        state_d = SSplit;
      end
      SSplit: begin
        if (lvl_q == want_q) begin
          m_wk = 1'b1; m_kind = ba_pkg::KindData;
          res_d = 32'(n_q) << (6'(deep_q - want_q) + 6'(sm_q));
          state_d = SDone;
        end else begin
          m_wk = 1'b1; m_kind = ba_pkg::KindSplit;
          lvl_d = lvl_q + 1'b1; n_d = {n_q[AddrW-2:0], 1'b0};
          t_d = head_q[lvl_q + 1'b1]; fix_d = 1'b0;
          state_d = SPush;
        end
      end
      SPush: begin
        // Pushes node n (or its buddy when splitting) onto level lvl.
        if (!fix_q && !t_q[LinkW-1]) begin
          m_addr = slot(lvl_q, t_q[AddrW-1:0]); m_wp = 1'b1;
          m_prev = {1'b0, push_n};
          fix_d = 1'b1;
        end else begin
          m_addr = slot(lvl_q, push_n);
          m_wk = 1'b1; m_kind = ba_pkg::KindFree;
          m_wp = 1'b1; m_wn = 1'b1; m_next = t_q;
          h_we = 1'b1; h_val = {1'b0, push_n};
          state_d = mrg_q ? SDone : SSplit;
        end
      end
      SWalkRd: begin
        state_d = SWalk;
      end
      SWalk: begin
        if (r_kind == ba_pkg::KindData) begin
          state_d = SDrop;
        end else if (r_kind != ba_pkg::KindSplit || lvl_q >= deep_q) begin
          st_d = ba_pkg::StNotAlloc; state_d = SDone;
        end else begin
          lvl_d = lvl_q + 1'b1; n_d = {n_q[AddrW-2:0], 1'b0};
          state_d = SWalkRd;
        end
      end
      SDrop: begin
        if (lvl_q == '0) begin
          m_addr = '0; m_wk = 1'b1; m_kind = ba_pkg::KindFree;
          m_wp = 1'b1; m_wn = 1'b1;
          h_we = 1'b1; h_val = '0; state_d = SDone;
        end else begin
          m_wk = 1'b1;
          state_d = SMergeRd;
        end
      end
      SMergeRd: begin
        m_addr = slot(lvl_q, n_q ^ AddrW'(1));
        state_d = SMerge;
      end
      SMerge: begin
        m_addr = slot(lvl_q, n_q ^ AddrW'(1));
        if (r_kind != ba_pkg::KindFree) begin
          mrg_d = 1'b1; t_d = head_q[lvl_q]; fix_d = 1'b0;
          state_d = SPush;
        end else begin
          m_wk = 1'b1; t_d = r_next; bp_d = r_prev; fix_d = 1'b0;
          state_d = SUnlink;
        end
      end
      SUnlink: begin
        if (!fix_q) begin
          if (!bp_q[LinkW-1]) begin
            m_addr = slot(lvl_q, bp_q[AddrW-1:0]); m_wn = 1'b1; m_next = t_q;
          end else begin
            h_we = 1'b1; h_val = t_q;
          end
          fix_d = 1'b1;
        end else begin
          if (!t_q[LinkW-1]) begin
            m_addr = slot(lvl_q, t_q[AddrW-1:0]); m_wp = 1'b1; m_prev = bp_q;
          end
          lvl_d = lvl_q - 1'b1; n_d = n_q >> 1; state_d = SDrop;
        end
      end
      SDone: begin
        if (!ovalid_q || rsp.ready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lg_q <= ba_pkg::LargestReset;
      sm_q <= ba_pkg::SmallestReset;
      ok_q <= 1'b1;
      deep_q <= LvlW'(ba_pkg::LargestReset);
      ovalid_q <= 1'b0;
      out_q <= '0;
      for (int k = 0; k < MaxLevels; k++) head_q[k] <= (k == 0) ? '0 : '1;
    end else begin
      if (clear) begin
        logic [4:0] nl, ns;
        logic       good;
        nl = (cfg_idx_i == ba_pkg::CfgLargest) ? cfg_val_i : lg_q;
        ns = (cfg_idx_i == ba_pkg::CfgSmallest) ? cfg_val_i : sm_q;
        good = (ns <= nl) && ((6'(nl) - 6'(ns)) < 6'(MaxLevels));
        lg_q <= nl; sm_q <= ns;
        ok_q <= good;
        deep_q <= good ? LvlW'(nl - ns) : '0;
        for (int k = 0; k < MaxLevels; k++) head_q[k] <= (k == 0) ? '0 : '1;
      end else if (h_we) begin
        head_q[h_lvl] <= h_val;
      end
      state_q <= state_d;
      if (state_q == SDone && (!ovalid_q || rsp.ready)) begin
        ovalid_q <= 1'b1;
        out_q <= '{result_index: (st_q == ba_pkg::StOk) ? res_q : '0, status: st_q};
      end else if (rsp.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; want_q <= want_d; n_q <= n_d; t_q <= t_d;
    bp_q <= bp_d; fix_q <= fix_d; mrg_q <= mrg_d; res_q <= res_d; st_q <= st_d;
  end

  assign req.ready = (state_q == SIdle) && !busy;
  assign rsp.valid = ovalid_q;
  assign rsp.data  = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == SIdle) else $error("accept outside idle");
  a_done_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone && (!rsp.valid || rsp.ready) |=> rsp.valid)
    else $error("result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed while waiting");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status != ba_pkg::StOk |-> rsp.data.result_index == '0)
    else $error("error with index");
endmodule

### rtl/buddy_allocator.sv
`timescale 1ns / 1ps

// Binary buddy allocator. One transaction is worked on at a time, and its
// result waits in an output register, so the next request can be taken while
// that result is still unread. After reset and after every register write the
// node store is cleared one node per cycle, which holds off requests until
// every node is cleared. A request rejected on acceptance, or a zero-size
// allocate, goes straight from idle to the done state. An allocate searches
// the free lists level by level towards larger blocks, pops a free block and
// splits it level by level, pushing each buddy onto its free list; a free walks
// down the tree to the data node, then merges with free buddies level by level,
// unlinking each from its list. Every step goes through the single-port node
// store with registered read data, and a transaction only completes once the
// output register is free.
module buddy_allocator #(
  parameter int unsigned MaxLevels = ba_pkg::MaxLevelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  ba_stream_if.sink   req,
  ba_stream_if.source rsp
);
  ba_core #(.MaxLevels(MaxLevels)) u_core (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]), .cfg_idx_ok_i(1'b1),
    .cfg_val_i(cfg_data_i), .req, .rsp
  );
endmodule
